/* sv/fbds_pkg.sv */
package fbds_pkg;

  // Field widths.
  localparam int ClkW  = 27;
  localparam int BaudW = 24;
  localparam int DivW  = 16;
  localparam int FracW = 4;
  localparam int ErrW  = 17;
  localparam int PctW  = 7;

  // Derived datapath widths.
  localparam int OversampleShift = 4;
  localparam int UW    = ClkW - OversampleShift;  // clock after divide by sixteen
  localparam int ProdW = UW + FracW;              // m * u
  localparam int DvdW  = ProdW;                   // widest dividend (m * u)
  localparam int DvsW  = BaudW;                   // widest divisor
  localparam int PlimW = BaudW + PctW;            // baud * percent
  localparam int DW    = ProdW + 1;               // rounded divisor before range check
  localparam int SumW  = FracW + 1;               // m + a
  localparam int StepW = 5;                       // divider step counter

  localparam logic [PctW-1:0]  PCT_RESET    = 7'd3;
  localparam logic [ErrW-1:0]  START_ERROR  = 17'd100000;
  localparam logic [FracW-1:0] FRAC_MAX     = 4'd15;
  localparam logic [FracW-1:0] MUL_FIRST    = 4'd1;
  localparam logic [FracW-1:0] ADD_FIRST    = 4'd0;
  localparam logic [DivW-1:0]  DIV_MIN      = 16'd3;
  localparam logic [PlimW-1:0] PERCENT_BASE = 31'd100;

  typedef enum logic [1:0] {
    DOP_SCALE,
    DOP_BAUD,
    DOP_RATE
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    div_start;
    div_op_t div_op;
    logic    update;
    logic    step;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic baud_zero;
    logic cand_valid;
    logic last;
    logic best_zero;
  } dp_sts_t;

endpackage

/* sv/fbds_if.sv */
interface fbds_in_if;
  import fbds_pkg::*;

  logic             valid;
  logic             ready;
  logic [ClkW-1:0]  peripheral_clock_hz;
  logic [BaudW-1:0] target_baud;

  modport source (output valid, output peripheral_clock_hz, output target_baud, input ready);
  modport sink   (input valid, input peripheral_clock_hz, input target_baud, output ready);
endinterface

interface fbds_out_if;
  import fbds_pkg::*;

  logic             valid;
  logic             ready;
  logic [DivW-1:0]  divisor_latch;
  logic [FracW-1:0] mul_value;
  logic [FracW-1:0] add_value;
  logic [ErrW-1:0]  best_error;
  logic             accepted;

  modport source (output valid, output divisor_latch, output mul_value, output add_value,
                  output best_error, output accepted, input ready);
  modport sink   (input valid, input divisor_latch, input mul_value, input add_value,
                  input best_error, input accepted, output ready);
endinterface

/* sv/fbds_div.sv */
module fbds_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fbds_pkg::DvdW-1:0] dividend,
  input  logic [fbds_pkg::DvsW-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [fbds_pkg::DvdW-1:0] quotient,
  output logic [fbds_pkg::DvsW-1:0] remainder
);
  import fbds_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(DvdW - 1);

  logic [DvdW-1:0]  quo_r;
  logic [DvsW-1:0]  rem_r;
  logic [DvsW-1:0]  dvs_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DvsW:0]    shifted;
  logic [DvsW:0]    diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of quo_r while the quotient bits shift in at the bottom.
  assign shifted = {rem_r, quo_r[DvdW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      quo_r <= {quo_r[DvdW-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // The remainder must be below the divisor whenever a division finishes.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule

/* sv/fbds_datapath.sv */
module fbds_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbds_pkg::ctrl_cmd_t        cmd,
  output fbds_pkg::dp_sts_t          sts,
  input  logic [fbds_pkg::ClkW-1:0]  clk_hz,
  input  logic [fbds_pkg::BaudW-1:0] baud,
  input  logic [fbds_pkg::PctW-1:0]  pct,
  output logic [fbds_pkg::DivW-1:0]  divisor_latch,
  output logic [fbds_pkg::FracW-1:0] mul_value,
  output logic [fbds_pkg::FracW-1:0] add_value,
  output logic [fbds_pkg::ErrW-1:0]  best_error,
  output logic                       accepted
);
  import fbds_pkg::*;

  logic [UW-1:0]    u_r;
  logic [BaudW-1:0] baud_r;
  logic [FracW-1:0] m_r;
  logic [FracW-1:0] a_r;
  logic [ProdW-1:0] prod_r;
  logic [PlimW-1:0] plim_r;
  logic [ProdW-1:0] t_r;
  logic [DW-1:0]    d_r;
  logic [ProdW-1:0] rate_r;
  div_op_t          op_r;

  logic [DivW-1:0]  best_div_r;
  logic [FracW-1:0] best_mul_r;
  logic [FracW-1:0] best_add_r;
  logic [ErrW-1:0]  best_err_r;

  logic [DivW-1:0]  out_div_r;
  logic [FracW-1:0] out_mul_r;
  logic [FracW-1:0] out_add_r;
  logic [ErrW-1:0]  out_err_r;
  logic             out_acc_r;

  logic [DvdW-1:0]  dvd;
  logic [DvsW-1:0]  dvs;
  logic             div_busy;
  logic             div_done;
  logic [DvdW-1:0]  quo;
  logic [DvsW-1:0]  rem;
  logic [SumW-1:0]  frac_sum;
  logic             round_up;
  logic [ProdW-1:0] baud_ext;
  logic [ProdW-1:0] err;
  logic [PlimW-1:0] acc_need;

  assign frac_sum = {1'b0, m_r} + {1'b0, a_r};
  assign baud_ext = ProdW'(baud_r);
  assign err      = (rate_r >= baud_ext) ? (rate_r - baud_ext) : (baud_ext - rate_r);
  assign round_up = (rem > (baud_r >> 1));

  // The error lies below the truncated percentage limit exactly when a hundred times
  // one more than the error still fits within baud * percent.
  assign acc_need = (PlimW'(best_err_r) + 1'b1) * PERCENT_BASE;

  always_comb begin
    case (cmd.div_op)
      DOP_SCALE: begin
        dvd = DvdW'(prod_r);
        dvs = DvsW'(frac_sum);
      end
      DOP_BAUD: begin
        dvd = DvdW'(t_r);
        dvs = baud_r;
      end
      DOP_RATE: begin
        dvd = DvdW'(t_r);
        dvs = DvsW'(d_r[DivW-1:0]);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  fbds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Search indices and the best candidate so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r        <= MUL_FIRST;
      a_r        <= ADD_FIRST;
      best_div_r <= '0;
      best_mul_r <= MUL_FIRST;
      best_add_r <= ADD_FIRST;
      best_err_r <= START_ERROR;
    end else if (cmd.load) begin
      m_r        <= MUL_FIRST;
      a_r        <= ADD_FIRST;
      best_div_r <= '0;
      best_mul_r <= MUL_FIRST;
      best_add_r <= ADD_FIRST;
      best_err_r <= START_ERROR;
    end else begin
      if (cmd.step) begin
        if (a_r == FRAC_MAX) begin
          a_r <= ADD_FIRST;
          m_r <= m_r + 1'b1;
        end else begin
          a_r <= a_r + 1'b1;
        end
      end
      // Strict less-than keeps the earliest candidate on a tie.
      if (cmd.update && (err < ProdW'(best_err_r))) begin
        best_div_r <= d_r[DivW-1:0];
        best_mul_r <= m_r;
        best_add_r <= a_r;
        best_err_r <= err[ErrW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r    <= clk_hz[ClkW-1:OversampleShift];
      baud_r <= baud;
      plim_r <= PlimW'(baud) * PlimW'(pct);
    end
    if (cmd.mul) begin
      prod_r <= ProdW'(m_r) * ProdW'(u_r);
    end
    if (cmd.div_start) begin
      op_r <= cmd.div_op;
    end
    if (div_done) begin
      case (op_r)
        DOP_SCALE: t_r     <= quo[ProdW-1:0];
        DOP_BAUD:  d_r     <= {1'b0, quo[ProdW-1:0]} + DW'(round_up);
        DOP_RATE:  rate_r  <= quo[ProdW-1:0];
        default:   rate_r  <= rate_r;
      endcase
    end
    if (cmd.out_load) begin
      out_div_r <= best_div_r;
      out_mul_r <= best_mul_r;
      out_add_r <= best_add_r;
      out_err_r <= best_err_r;
      out_acc_r <= (acc_need <= plim_r);
    end
  end

  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.baud_zero  = (baud_r == '0);
  assign sts.cand_valid = (d_r[DW-1:DivW] == '0) && (d_r[DivW-1:0] >= DIV_MIN);
  assign sts.last       = (m_r == FRAC_MAX) && (a_r == FRAC_MAX);
  assign sts.best_zero  = (best_err_r == '0);

  assign divisor_latch = out_div_r;
  assign mul_value     = out_mul_r;
  assign add_value     = out_add_r;
  assign best_error    = out_err_r;
  assign accepted      = out_acc_r;

  // An update may only improve the best error.
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (best_err_r <= $past(best_err_r)))
    else $error("best error grew on update");

  // A recorded divisor is always one of the valid divisors.
  a_best_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (best_div_r != '0) |-> ((best_div_r >= DIV_MIN) && (best_err_r < START_ERROR)))
    else $error("recorded divisor out of range");

endmodule

/* sv/fbds_ctrl.sv */
module fbds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output fbds_pkg::ctrl_cmd_t cmd,
  input  fbds_pkg::dp_sts_t   sts
);
  import fbds_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_START   = 13'b0000000000010,
    S_MUL     = 13'b0000000000100,
    S_SCALE   = 13'b0000000001000,
    S_SCALE_W = 13'b0000000010000,
    S_BAUD    = 13'b0000000100000,
    S_BAUD_W  = 13'b0000001000000,
    S_CHECK   = 13'b0000010000000,
    S_RATE    = 13'b0000100000000,
    S_RATE_W  = 13'b0001000000000,
    S_UPDATE  = 13'b0010000000000,
    S_NEXT    = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.div_op = DOP_SCALE;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = sts.baud_zero ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_SCALE;
        state_nxt     = S_SCALE_W;
      end
      S_SCALE_W: begin
        if (sts.div_done) begin
          state_nxt = S_BAUD;
        end
      end
      S_BAUD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_BAUD;
        state_nxt     = S_BAUD_W;
      end
      S_BAUD_W: begin
        if (sts.div_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.cand_valid ? S_RATE : S_NEXT;
      end
      S_RATE: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_RATE;
        state_nxt     = S_RATE_W;
      end
      S_RATE_W: begin
        if (sts.div_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        // An exact match cannot be beaten, so the search ends there.
        if (sts.best_zero || sts.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The shared divider is never restarted while it is still working.
  a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A new result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // Division results only arrive while the sequencer is waiting for them.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> ((state_r == S_SCALE_W) || (state_r == S_BAUD_W) ||
                      (state_r == S_RATE_W)))
    else $error("division finished outside a wait state");

endmodule

/* sv/fractional_baud_divisor_search_unit.sv */
// Fractional baud divisor search: each request carries a peripheral clock and a
// target baud rate and yields one result with the best divisor latch value,
// fractional multiplier and add value, their baud error and an accept flag set
// when that error is below the configured percentage of the target rate,
// truncated to a whole number. A single shared divider producing one quotient
// bit per cycle does the searching; each candidate takes a scaling and a baud
// division, and a rate division only when its divisor is in range. Up to 240
// candidates are tried, fewer on an exact match; a request with a zero baud rate
// skips the search. The finished result moves into the output register as soon
// as that register is free, and the next request is taken in the following
// cycle, even while that result still waits to be taken.
module fractional_baud_divisor_search_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  fbds_in_if.sink                   in_req,
  fbds_out_if.source                out_res,
  input  logic                      cfg_we,
  input  logic [fbds_pkg::PctW-1:0] cfg_wdata
);
  import fbds_pkg::*;

  logic [PctW-1:0] pct_r;
  ctrl_cmd_t       cmd;
  dp_sts_t         sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (cfg_we) begin
      pct_r <= cfg_wdata;
    end
  end

  fbds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  fbds_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .clk_hz        (in_req.peripheral_clock_hz),
    .baud          (in_req.target_baud),
    .pct           (pct_r),
    .divisor_latch (out_res.divisor_latch),
    .mul_value     (out_res.mul_value),
    .add_value     (out_res.add_value),
    .best_error    (out_res.best_error),
    .accepted      (out_res.accepted)
  );

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbds_pkg::*;

  localparam int CycleLimit = 15_000_000;

  typedef struct packed {
    logic [DivW-1:0]  divisor_latch;
    logic [FracW-1:0] mul_value;
    logic [FracW-1:0] add_value;
    logic [ErrW-1:0]  best_error;
    logic             accepted;
  } baud_setting_t;

  class divisor_scoreboard;
    baud_setting_t   awaited[$];
    logic [PctW-1:0] error_pct;
    int              errors;
    int              results_seen;

    function new();
      error_pct    = PCT_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Walks the multipliers and add values in the same order as the hardware, so that the
    // first setting found with a given error is the one kept.
    function baud_setting_t search_divisor(input logic [ClkW-1:0] clk_hz,
                                           input logic [BaudW-1:0] baud);
      baud_setting_t s;
      bit [31:0] u, t, d, rate, err, best_err, rate_hz;
      bit [63:0] lim;
      bit        exact;
      s.divisor_latch = '0;
      s.mul_value     = MUL_FIRST;
      s.add_value     = ADD_FIRST;
      best_err        = START_ERROR;
      exact           = 1'b0;
      rate_hz         = baud;
      u               = 32'(clk_hz) >> OversampleShift;
      if (rate_hz != 0) begin
        for (int m = 1; m <= FRAC_MAX && !exact; m++) begin
          for (int a = 0; a <= FRAC_MAX && !exact; a++) begin
            t = (32'(m) * u) / 32'(m + a);
            d = t / rate_hz;
            if ((t % rate_hz) > (rate_hz / 2))
              d++;
            if (d >= DIV_MIN && d < (32'd1 << DivW)) begin
              rate = t / d;
              err  = (rate <= rate_hz) ? (rate_hz - rate) : (rate - rate_hz);
              if (err < best_err) begin
                best_err        = err;
                s.divisor_latch = d[DivW-1:0];
                s.mul_value     = m[FracW-1:0];
                s.add_value     = a[FracW-1:0];
                exact           = (err == 0);
              end
            end
          end
        end
      end
      lim          = (64'(rate_hz) * 64'(error_pct)) / 64'd100;
      s.best_error = best_err[ErrW-1:0];
      s.accepted   = (64'(best_err) < lim);
      return s;
    endfunction

    function void note_request(input logic [ClkW-1:0] clk_hz, input logic [BaudW-1:0] baud);
      awaited.push_back(search_divisor(clk_hz, baud));
    endfunction

    task check_result(input baud_setting_t got);
      baud_setting_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
        return;
      end
      want = awaited.pop_front();
      if (got.divisor_latch !== want.divisor_latch || got.mul_value !== want.mul_value ||
          got.add_value !== want.add_value || got.best_error !== want.best_error ||
          got.accepted !== want.accepted)
        report($sformatf({"result %0d: got dl %0d mul %0d add %0d err %0d acc %0b, ",
                          "want dl %0d mul %0d add %0d err %0d acc %0b"}, results_seen,
                         got.divisor_latch, got.mul_value, got.add_value, got.best_error,
                         got.accepted, want.divisor_latch, want.mul_value, want.add_value,
                         want.best_error, want.accepted));
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [PctW-1:0] cfg_wdata;

  fbds_in_if  in_req();
  fbds_out_if out_res();

  fractional_baud_divisor_search_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  divisor_scoreboard sb = new();

  bit          sender_idles;
  bit          sink_idles;
  int          hold_cycles;
  int unsigned cycles;

  int unsigned std_bauds[12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                 115200, 230400, 460800, 921600};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: a fresh stall is drawn after every accepted result, and a long hold
  // requested by the stimulus overrides whatever stall is in progress.
  initial begin
    int stall;
    stall = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        sb.check_result('{out_res.divisor_latch, out_res.mul_value, out_res.add_value,
                          out_res.best_error, out_res.accepted});
        stall = sink_idles ? $urandom_range(0, 14) : 0;
      end
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        stall--;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input logic [ClkW-1:0] clk_hz, input logic [BaudW-1:0] baud);
    int gap;
    gap = sender_idles ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid               <= 1'b1;
    in_req.peripheral_clock_hz <= clk_hz;
    in_req.target_baud         <= baud;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(clk_hz, baud);
  endtask

  // The register only changes once the block has drained.
  task automatic set_error_pct(input logic [PctW-1:0] pct);
    in_req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pct;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.error_pct = pct;
  endtask

  task automatic run_random(input int n);
    logic [ClkW-1:0]  clk_hz;
    logic [BaudW-1:0] baud;
    int unsigned      u;
    int unsigned      hi;
    for (int i = 0; i < n; i++) begin
      clk_hz = ClkW'($urandom);
      baud   = BaudW'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          // Raw values, mostly without any divisor in range.
        end
        1, 2, 3: baud = BaudW'(std_bauds[$urandom_range(0, 11)]);
        default: begin
          u  = 32'(clk_hz) >> OversampleShift;
          hi = (u / 3) >> $urandom_range(0, 12);
          if (hi == 0)
            hi = 1;
          baud = BaudW'($urandom_range(1, hi));
        end
      endcase
      send_req(clk_hz, baud);
    end
  endtask

  initial begin
    hold_cycles                = 0;
    sender_idles               = 1'b1;
    sink_idles                 = 1'b1;
    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_wdata                  <= '0;
    in_req.valid               <= 1'b0;
    in_req.peripheral_clock_hz <= '0;
    in_req.target_baud         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset percentage.
    send_req(27'd0, 24'd1);                    // zero clock
    send_req(27'd0, 24'hFFFFFF);
    send_req(27'h7FFFFFF, 24'd0);              // zero baud rate
    send_req(27'd0, 24'd0);
    send_req(27'h7FFFFFF, 24'hFFFFFF);         // every divisor rounds below three
    send_req(27'h7FFFFFF, 24'd1);              // every divisor above the range
    send_req(27'd18432000, 24'd115200);        // exact match on the first candidate
    send_req(27'd1843200, 24'd9600);
    send_req(27'd48000, 24'd1000);             // smallest legal divisor, exact
    send_req(27'd32000, 24'd1000);             // no divisor above two is reachable
    send_req(27'd1048560, 24'd1);              // largest legal divisor, exact
    send_req(27'd1048576, 24'd1);              // first candidate just out of range
    send_req(27'd40000, 24'd1000);             // remainder of exactly half: no round-up
    send_req(27'd56000, 24'd1000);
    send_req(27'd56016, 24'd1000);             // remainder just over half: round-up
    send_req(27'd25000000, 24'd9600);
    send_req(27'd100000000, 24'd115200);
    send_req(27'd12000000, 24'd19200);
    send_req(27'd72000000, 24'd921600);
    send_req(27'd134000000, 24'd3000000);

    set_error_pct(7'd0);
    run_random(18);

    set_error_pct(7'h7F);
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    run_random(18);

    // Hold the result side off while zero-baud requests, which finish quickly, keep coming,
    // so that the block backs up and drops its input ready.
    set_error_pct(7'd100);
    hold_cycles = 4000;
    for (int i = 0; i < 6; i++)
      send_req(ClkW'($urandom), 24'd0);
    send_req(27'd50000000, 24'd57600);
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    run_random(18);

    set_error_pct(7'd1);
    run_random(18);

    set_error_pct(PctW'($urandom_range(0, 127)));
    sender_idles = 1'b0;
    run_random(9);
    sender_idles = 1'b1;
    sink_idles   = 1'b0;
    run_random(9);

    in_req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
sv/fbds_pkg.sv
sv/fbds_if.sv
sv/fbds_div.sv
sv/fbds_datapath.sv
sv/fbds_ctrl.sv
sv/fractional_baud_divisor_search_unit.sv
sim/tb.sv
